@@ rtl/longest_palindrome_finder_top_macros.svh @@
// Assertion macros for the longest palindrome finder top level.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef LONGEST_PALINDROME_FINDER_TOP_MACROS_SVH
`define LONGEST_PALINDROME_FINDER_TOP_MACROS_SVH

// The property must hold on every clock edge outside reset.
`define PLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the cycle where the antecedent holds.
`define PLF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/plf_pkg.sv @@
// Shared types and constants for the longest palindrome finder.
// Used by plf_search and longest_palindrome_finder_top.
package plf_pkg;

  localparam int unsigned PalStartW  = 6;
  localparam int unsigned PalLengthW = 7;

  typedef struct packed {
    logic [PalStartW-1:0]  start;
    logic [PalLengthW-1:0] length;
  } plf_res_t;

endpackage

@@ rtl/plf_buffer.sv @@
// Text buffer of the palindrome finder: one write port and two read ports.
// Read data is registered; no dependencies.
module plf_buffer #(
  parameter int unsigned MAX_LEN = 64,
  localparam int unsigned AW = $clog2(MAX_LEN)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_a_addr_i,
  input  logic [AW-1:0] rd_b_addr_i,
  output logic [7:0]    rd_a_data_o,
  output logic [7:0]    rd_b_data_o
);

  logic [7:0] mem [MAX_LEN];
  logic [7:0] rd_a_q;
  logic [7:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

@@ rtl/plf_search.sv @@
// Search sequencer: walks candidate spans from longest to shortest, greatest
// start first, comparing one byte pair per step. Depends on plf_pkg.
module plf_search #(
  parameter int unsigned MAX_LEN = 64,
  localparam int unsigned AW = $clog2(MAX_LEN),
  localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [LW-1:0]       n_i,
  output logic [AW-1:0]       rd_lo_addr_o,
  output logic [AW-1:0]       rd_hi_addr_o,
  input  logic [7:0]          rd_lo_data_i,
  input  logic [7:0]          rd_hi_data_i,
  output logic                busy_o,
  output logic                done_o,
  output plf_pkg::plf_res_t   result_o
);

  import plf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_CHECK
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] n_q, n_d;
  logic [LW-1:0] len_q, len_d;
  logic [AW-1:0] s_q, s_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [AW-1:0] best_start_q, best_start_d;
  logic [LW-1:0] best_len_q, best_len_d;
  logic          done_q, done_d;
  logic [LW:0]   shift_hi;
  logic [LW-1:0] len_dec;

  assign shift_hi = (LW+1)'(s_q) + (LW+1)'(len_q) - (LW+1)'(2);
  assign len_dec  = len_q - LW'(1);

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    len_d        = len_q;
    s_d          = s_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    done_d       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d = n_i;
          if (n_i == '0) begin
            best_start_d = '0;
            best_len_d   = '0;
            done_d       = 1'b1;
          end else begin
            len_d   = n_i;
            s_d     = '0;
            lo_d    = '0;
            hi_d    = AW'(n_i - LW'(1));
            state_d = S_TEST;
          end
        end
      end
      S_TEST: begin
        if (lo_q >= hi_q) begin
          best_start_d = s_q;
          best_len_d   = len_q;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_TEST;
        if (rd_lo_data_i == rd_hi_data_i) begin
          lo_d = lo_q + AW'(1);
          hi_d = hi_q - AW'(1);
        end else if (s_q != '0) begin
          s_d  = s_q - AW'(1);
          lo_d = s_q - AW'(1);
          hi_d = AW'(shift_hi);
        end else begin
          len_d = len_dec;
          s_d   = AW'(n_q - len_dec);
          lo_d  = AW'(n_q - len_dec);
          hi_d  = AW'(n_q - LW'(1));
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    len_q        <= len_d;
    s_q          <= s_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
  end

  assign rd_lo_addr_o    = lo_q;
  assign rd_hi_addr_o    = hi_q;
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign result_o.start  = PalStartW'(best_start_q);
  assign result_o.length = PalLengthW'(best_len_q);

endmodule

@@ rtl/longest_palindrome_finder_top.sv @@
// Longest palindrome finder: the input channel loads a string byte by byte;
// the item marked last starts a search over the buffered text and one item
// with the start and length of the longest palindrome leaves on the output
// channel, the greatest start winning among equal lengths. An empty string
// gives start 0 and length 0; overflow reports bytes dropped beyond MAX_LEN.
// Items load while in_ready_o is high. After the last item, in_ready_o stays low
// while one byte comparator walks the spans through the two buffer read ports.
// Each byte pair compared, a mismatching pair included, takes a test step
// and a check step; the palindrome found ends with one more test step.
// When the search is done and the output register is free, the result is
// registered there. The next string loads while a result waits for out_ready_i;
// if its search ends before that result is taken, the new result is held and
// in_ready_o stays low until the output register frees up.
// Reset empties the string, clears the overflow flag and empties the output register;
// its data fields and the buffer contents are not reset.
// Depends on plf_pkg, plf_buffer, plf_search and the assertion macro header.
module longest_palindrome_finder_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         char_byte_i,
  input  logic                               char_present_i,
  input  logic                               last_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [plf_pkg::PalStartW-1:0]      pal_start_o,
  output logic [plf_pkg::PalLengthW-1:0]     pal_length_o,
  output logic                               overflow_o
);

  import plf_pkg::*;

  `include "longest_palindrome_finder_top_macros.svh"

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    T_LOAD,
    T_SEARCH,
    T_HOLD
  } state_e;

  state_e              state_q, state_d;
  logic [LW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;
  logic                ovf_res_q, ovf_res_d;
  logic                out_valid_q, out_valid_d;
  logic [PalStartW-1:0]  pal_start_q, pal_start_d;
  logic [PalLengthW-1:0] pal_length_q, pal_length_d;
  logic                overflow_q, overflow_d;

  logic                in_acc;
  logic                has_room;
  logic                wr_en;
  logic                srch_start;
  logic [LW-1:0]       srch_n;
  logic                out_free;
  logic                load_out;
  logic [AW-1:0]       rd_lo_addr;
  logic [AW-1:0]       rd_hi_addr;
  logic [7:0]          rd_lo_data;
  logic [7:0]          rd_hi_data;
  logic                srch_busy;
  logic                srch_done;
  plf_res_t            srch_res;

  assign in_ready_o = (state_q == T_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign has_room   = (count_q < LW'(MAX_LEN));
  assign wr_en      = in_acc && char_present_i && has_room;
  assign srch_start = in_acc && last_item_i;
  assign srch_n     = count_q + LW'(wr_en);
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = out_free &&
                      (((state_q == T_SEARCH) && srch_done) || (state_q == T_HOLD));

  plf_buffer #(
    .MAX_LEN (MAX_LEN)
  ) u_buffer (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (count_q[AW-1:0]),
    .wr_data_i   (char_byte_i),
    .rd_a_addr_i (rd_lo_addr),
    .rd_b_addr_i (rd_hi_addr),
    .rd_a_data_o (rd_lo_data),
    .rd_b_data_o (rd_hi_data)
  );

  plf_search #(
    .MAX_LEN (MAX_LEN)
  ) u_search (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (srch_start),
    .n_i          (srch_n),
    .rd_lo_addr_o (rd_lo_addr),
    .rd_hi_addr_o (rd_hi_addr),
    .rd_lo_data_i (rd_lo_data),
    .rd_hi_data_i (rd_hi_data),
    .busy_o       (srch_busy),
    .done_o       (srch_done),
    .result_o     (srch_res)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    ovf_res_d    = ovf_res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    pal_start_d  = pal_start_q;
    pal_length_d = pal_length_q;
    overflow_d   = overflow_q;
    case (state_q)
      T_LOAD: begin
        if (in_acc) begin
          if (wr_en) begin
            count_d = count_q + LW'(1);
          end
          if (char_present_i && !has_room) begin
            ovf_d = 1'b1;
          end
          if (last_item_i) begin
            ovf_res_d = ovf_q || (char_present_i && !has_room);
            count_d   = '0;
            ovf_d     = 1'b0;
            state_d   = T_SEARCH;
          end
        end
      end
      T_SEARCH: begin
        if (srch_done) begin
          state_d = load_out ? T_LOAD : T_HOLD;
        end
      end
      T_HOLD: begin
        if (load_out) begin
          state_d = T_LOAD;
        end
      end
      default: begin
        state_d = T_LOAD;
      end
    endcase
    if (load_out) begin
      out_valid_d  = 1'b1;
      pal_start_d  = srch_res.start;
      pal_length_d = srch_res.length;
      overflow_d   = ovf_res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_res_q    <= ovf_res_d;
    pal_start_q  <= pal_start_d;
    pal_length_q <= pal_length_d;
    overflow_q   <= overflow_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pal_start_o  = pal_start_q;
  assign pal_length_o = pal_length_q;
  assign overflow_o   = overflow_q;

  `PLF_ASSERT_IMP(a_done_in_search, srch_done, state_q == T_SEARCH,
                  "search finished outside the search state")
  `PLF_ASSERT_IMP(a_no_load_while_busy, srch_busy, !in_ready_o,
                  "input accepted while the search was running")
  `PLF_ASSERT_IMP(a_empty_start_zero, out_valid_o && (pal_length_o == '0),
                  pal_start_o == '0, "empty result with a nonzero start")
  `PLF_ASSERT(a_count_bounded, count_q <= LW'(MAX_LEN),
              "stored byte count exceeds the buffer depth")

endmodule

@@ tb/sv/longest_palindrome_finder_checker.sv @@
// Checker for the longest palindrome finder: watches both channels, predicts each result
// from the accepted string bytes and compares it field by field with the block's output.
// Depends on plf_pkg for the result field widths.
module longest_palindrome_finder_checker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [7:0]                     char_byte_i,
  input  logic                           char_present_i,
  input  logic                           last_item_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [plf_pkg::PalStartW-1:0]  pal_start_i,
  input  logic [plf_pkg::PalLengthW-1:0] pal_length_i,
  input  logic                           overflow_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    awaited_count_o
);

  typedef struct packed {
    plf_pkg::plf_res_t pal;
    logic              overflow;
  } pal_answer_t;

  logic [7:0]  text_mem [MAX_LEN];
  int unsigned text_len;
  bit          text_clipped;
  pal_answer_t awaited_q [$];
  pal_answer_t want;
  int unsigned mismatch_total = 0;

  assign mismatches_o = mismatch_total;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  // Longest span first and, within one length, the greatest start first.
  function automatic pal_answer_t longest_mirror();
    pal_answer_t ans;
    int          span;
    int          first;
    int          lo;
    int          hi;
    bit          mirrored;
    bit          done;
    ans  = '0;
    done = 1'b0;
    for (span = int'(text_len); span > 0 && !done; span--) begin
      for (first = int'(text_len) - span; first >= 0 && !done; first--) begin
        lo       = first;
        hi       = first + span - 1;
        mirrored = 1'b1;
        while (lo < hi) begin
          if (text_mem[lo] != text_mem[hi]) mirrored = 1'b0;
          lo++;
          hi--;
        end
        if (mirrored) begin
          ans.pal.start  = first[plf_pkg::PalStartW-1:0];
          ans.pal.length = span[plf_pkg::PalLengthW-1:0];
          done           = 1'b1;
        end
      end
    end
    ans.overflow = text_clipped;
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_len     = 0;
      text_clipped = 1'b0;
      awaited_q.delete();
      awaited_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited: start %0d length %0d ovf %0b",
                                    pal_start_i, pal_length_i, overflow_i));
        end else begin
          want = awaited_q.pop_front();
          if (pal_start_i !== want.pal.start)
            report_mismatch($sformatf("pal_start %0d, expected %0d", pal_start_i,
                                      want.pal.start));
          if (pal_length_i !== want.pal.length)
            report_mismatch($sformatf("pal_length %0d, expected %0d", pal_length_i,
                                      want.pal.length));
          if (overflow_i !== want.overflow)
            report_mismatch($sformatf("overflow %0b, expected %0b", overflow_i,
                                      want.overflow));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (char_present_i) begin
          if (text_len < MAX_LEN) begin
            text_mem[text_len] = char_byte_i;
            text_len++;
          end else begin
            text_clipped = 1'b1;
          end
        end
        if (last_item_i) begin
          awaited_q.push_back(longest_mirror());
          text_len     = 0;
          text_clipped = 1'b0;
        end
      end
      awaited_count_o <= awaited_q.size();
    end
  end

endmodule

@@ tb/sv/longest_palindrome_finder_top_test.sv @@
// Testbench top for the longest palindrome finder: clock, reset, string stimulus with
// random idling on both channels, a watchdog and the final verdict.
// Depends on plf_pkg, longest_palindrome_finder_top and longest_palindrome_finder_checker.
module longest_palindrome_finder_top_test;

  localparam int unsigned MaxLen     = 64;
  localparam int unsigned TotalItems = 1550;
  localparam int unsigned QuietLimit = 600000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned TailCycles = 300;

  logic clk_i          = 1'b0;
  logic rst_ni         = 1'b0;
  logic in_valid_i     = 1'b0;
  logic [7:0] char_byte_i = 8'h00;
  logic char_present_i = 1'b0;
  logic last_item_i    = 1'b0;
  logic out_ready_i    = 1'b0;

  logic                           in_ready_o;
  logic                           out_valid_o;
  logic [plf_pkg::PalStartW-1:0]  pal_start_o;
  logic [plf_pkg::PalLengthW-1:0] pal_length_o;
  logic                           overflow_o;

  int unsigned fail_count;
  int unsigned pending_results;

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 72;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned items_sent    = 0;

  logic [7:0] text_q [$];
  logic [7:0] symbols [3];

  longest_palindrome_finder_top #(
    .MAX_LEN(MaxLen)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_byte_i   (char_byte_i),
    .char_present_i(char_present_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pal_start_o   (pal_start_o),
    .pal_length_o  (pal_length_o),
    .overflow_o    (overflow_o)
  );

  longest_palindrome_finder_checker #(
    .MAX_LEN(MaxLen)
  ) pal_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .char_present_i (char_present_i),
    .last_item_i    (last_item_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pal_start_i    (pal_start_o),
    .pal_length_i   (pal_length_o),
    .overflow_i     (overflow_o),
    .mismatches_o   (fail_count),
    .awaited_count_o(pending_results)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HoldCycles;
      out_ready_i  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("longest_palindrome_finder_top_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] draw_symbol(input int unsigned alpha);
    if (alpha == 0) return 8'($urandom_range(255));
    return symbols[$urandom_range(alpha - 1)];
  endfunction

  task automatic fill_random(input int unsigned len, input int unsigned alpha);
    text_q.delete();
    repeat (len) text_q.push_back(draw_symbol(alpha));
  endtask

  task automatic send_item(input logic [7:0] byte_val, input logic present, input logic last);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      gap = ($urandom_range(7) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 1);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_byte_i    <= byte_val;
    char_present_i <= present;
    last_item_i    <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (present || last) items_sent++;
  endtask

  task automatic send_text(input bit own_terminator);
    int unsigned idx;
    bit          tail_item;
    tail_item = own_terminator || text_q.size() == 0;
    for (idx = 0; idx < text_q.size(); idx++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(text_q[idx], 1'b1, !tail_item && idx == text_q.size() - 1);
    end
    if (tail_item) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned kind;
    int unsigned alpha;
    int unsigned half;
    int unsigned phase;
    int          first;
    int          idx;
    phase = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    text_q.delete();
    send_text(1'b1);
    text_q = '{8'h00};
    send_text(1'b0);
    text_q = '{8'hFF};
    send_text(1'b0);
    text_q = '{8'h61, 8'h62};
    send_text(1'b1);
    text_q = '{8'h00, 8'hFF, 8'h00};
    send_text(1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    text_q = '{8'h55, 8'hAA, 8'hAA, 8'h55, 8'h01};
    send_text(1'b1);

    symbols[0] = 8'($urandom_range(255));
    fill_random(MaxLen, 1);
    send_text(1'b0);
    fill_random(MaxLen + 3, 0);
    send_text(1'b1);

    while (items_sent < TotalItems) begin
      if (phase == 0 && items_sent >= TotalItems / 3) begin
        drain_results();
        phase         = 1;
        send_idle_pct = 72;
        recv_idle_pct <= 10;
      end else if (phase == 1 && items_sent >= 2 * TotalItems / 3) begin
        drain_results();
        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
      end
      for (idx = 0; idx < 3; idx++) symbols[idx] = 8'($urandom_range(255));
      alpha = $urandom_range(3, 2);
      kind  = $urandom_range(99);
      if (kind < 40) begin
        fill_random($urandom_range(12, 1), alpha);
      end else if (kind < 60) begin
        if ($urandom_range(1)) alpha = 0;
        fill_random($urandom_range(3), alpha);
        first = text_q.size();
        half  = $urandom_range(8);
        repeat (half) text_q.push_back(draw_symbol(alpha));
        if ($urandom_range(1)) text_q.push_back(draw_symbol(alpha));
        for (idx = first + int'(half) - 1; idx >= first; idx--) text_q.push_back(text_q[idx]);
        repeat ($urandom_range(3)) text_q.push_back(draw_symbol(alpha));
      end else if (kind < 80) begin
        fill_random($urandom_range(16, 1), 0);
      end else if (kind < 88) begin
        fill_random($urandom_range(40, 17), alpha);
      end else if (kind < 92) begin
        fill_random($urandom_range(MaxLen, MaxLen - 1), 0);
      end else if (kind < 95) begin
        fill_random($urandom_range(MaxLen + 6, MaxLen + 1), $urandom_range(1) ? 1 : 0);
      end else if (kind < 98) begin
        text_q.delete();
      end else begin
        fill_random($urandom_range(MaxLen, 1), 1);
      end
      send_text($urandom_range(1));
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("longest_palindrome_finder_top_test OK");
    end else begin
      $display("longest_palindrome_finder_top_test NOT OK");
    end
    $finish;
  end

endmodule
